### design/sida_pkg.sv
// Shared constants and types for the signed integer to decimal text converter.
`timescale 1ns / 1ps

package sida_pkg;

    localparam int NUM_W   = 32;                 // input number width
    localparam int CHAR_W  = 8;                  // ASCII character width
    localparam int DIG_W   = 4;                  // one BCD digit
    localparam int NDIG    = 10;                 // decimal digits of a 32-bit magnitude
    localparam int BCD_W   = NDIG * DIG_W;
    localparam int CNT_W   = $clog2(NUM_W);      // bit counter of the dabble pass
    localparam int LEFT_W  = $clog2(NDIG + 1);   // digits still to send

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;
    localparam logic [DIG_W-1:0]  RADIX       = 4'd10;
    localparam logic [DIG_W-1:0]  DABBLE_MIN  = 4'd5;   // digit needing +3 before shift
    localparam logic [DIG_W-1:0]  DABBLE_ADD  = 4'd3;

    // Converted number handed from the dabble stage to the character stage
    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } t_conv;

endpackage

### design/sida_if.sv
// Valid/ready channel interfaces for the number input and the character output.
`timescale 1ns / 1ps

interface sida_num_if import sida_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [NUM_W-1:0] number;

    modport src (output valid, output number, input ready);
    modport snk (input valid, input number, output ready);
endinterface

interface sida_char_if import sida_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport src (output valid, output character, output last, input ready);
    modport snk (input valid, input character, input last, output ready);
endinterface

### design/sida_dabble.sv
// Bit-serial double-dabble: takes the magnitude one bit a cycle into ten BCD digits.
`timescale 1ns / 1ps

module sida_dabble import sida_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sida_num_if.snk        i_num,
    output logic           o_conv_valid,
    input  logic           i_conv_ready,
    output t_conv          o_conv
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_DONE
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_cnt,   n_cnt;
    logic [NUM_W-1:0]      r_mag,   n_mag;
    logic [BCD_W-1:0]      r_bcd,   n_bcd;
    logic                  r_neg,   n_neg;
    logic [BCD_W-1:0]      w_adj;
    logic [NUM_W-1:0]      w_abs;
    logic                  w_take;

    // Absolute value; the most negative input maps to 2^31 unsigned
    assign w_abs  = i_num.number[NUM_W-1] ? (~i_num.number + NUM_W'(1)) : i_num.number;
    assign w_take = i_num.valid && (r_state == ST_IDLE);

    // Add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (r_bcd[i*DIG_W +: DIG_W] >= DABBLE_MIN) begin
                w_adj[i*DIG_W +: DIG_W] = r_bcd[i*DIG_W +: DIG_W] + DABBLE_ADD;
            end else begin
                w_adj[i*DIG_W +: DIG_W] = r_bcd[i*DIG_W +: DIG_W];
            end
        end
    end

    // Next-state logic
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_mag   = r_mag;
        n_bcd   = r_bcd;
        n_neg   = r_neg;
        case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    n_neg   = i_num.number[NUM_W-1];
                    n_mag   = w_abs;
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                n_bcd = {w_adj[BCD_W-2:0], r_mag[NUM_W-1]};
                n_mag = {r_mag[NUM_W-2:0], 1'b0};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_conv_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_mag <= n_mag;
        r_bcd <= n_bcd;
        r_neg <= n_neg;
    end

    assign i_num.ready  = (r_state == ST_IDLE);
    assign o_conv_valid = (r_state == ST_DONE);
    assign o_conv.neg   = r_neg;
    assign o_conv.bcd   = r_bcd;

    // An accepted number always starts a fresh 32-bit pass
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> (r_state == ST_SHIFT) && (r_cnt == '0))
        else $error("dabble pass did not start after transfer");

    // Largest magnitude is 2147483648, so the top digit never exceeds 2
    a_top_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_conv_valid |-> (r_bcd[BCD_W-1 -: DIG_W] <= DIG_W'(2)))
        else $error("top BCD digit out of range");

    // Lowest digit is always a valid decimal digit on handoff
    a_low_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_conv_valid |-> (r_bcd[DIG_W-1:0] < RADIX))
        else $error("low BCD digit out of range");

    // The shift at count NUM_W - 1 ends the pass and leads to handoff
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT && r_cnt == CNT_W'(NUM_W - 1)) |=> o_conv_valid)
        else $error("dabble pass length wrong");

endmodule

### design/sida_emit.sv
// Character serializer: drops leading zeros, then sends sign and digits one a transfer.
`timescale 1ns / 1ps

module sida_emit import sida_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_conv_valid,
    output logic           o_conv_ready,
    input  t_conv          i_conv,
    sida_char_if.src       o_char
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SKIP,
        ST_EMIT
    } t_state;

    t_state               r_state, n_state;
    logic [BCD_W-1:0]     r_bcd,   n_bcd;
    logic [LEFT_W-1:0]    r_left,  n_left;
    logic                 r_sign,  n_sign;
    logic                 r_ovalid, n_ovalid;
    logic [CHAR_W-1:0]    r_char,  n_char;
    logic                 r_last,  n_last;
    logic [DIG_W-1:0]     w_top;
    logic                 w_slot;
    logic                 w_load;

    assign w_top  = r_bcd[BCD_W-1 -: DIG_W];
    assign w_slot = !r_ovalid || o_char.ready;
    assign w_load = i_conv_valid && (r_state == ST_IDLE);

    // Next-state logic
    always_comb begin
        n_state  = r_state;
        n_bcd    = r_bcd;
        n_left   = r_left;
        n_sign   = r_sign;
        n_ovalid = r_ovalid && !o_char.ready;
        n_char   = r_char;
        n_last   = r_last;
        case (r_state)
            ST_IDLE: begin
                if (w_load) begin
                    n_bcd   = i_conv.bcd;
                    n_sign  = i_conv.neg;
                    n_left  = LEFT_W'(NDIG);
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // One leading zero dropped per cycle; the units digit always stays
                if (w_top == '0 && r_left > LEFT_W'(1)) begin
                    n_bcd  = {r_bcd[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
                    n_left = r_left - LEFT_W'(1);
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_slot) begin
                    n_ovalid = 1'b1;
                    if (r_sign) begin
                        n_char = ASCII_MINUS;
                        n_last = 1'b0;
                        n_sign = 1'b0;
                    end else begin
                        n_char = ASCII_ZERO + CHAR_W'(w_top);
                        n_last = (r_left == LEFT_W'(1));
                        n_bcd  = {r_bcd[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
                        n_left = r_left - LEFT_W'(1);
                        if (r_left == LEFT_W'(1)) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_left   <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_left   <= n_left;
        end
        r_bcd  <= n_bcd;
        r_sign <= n_sign;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_conv_ready     = (r_state == ST_IDLE);
    assign o_char.valid     = r_ovalid;
    assign o_char.character = r_char;
    assign o_char.last      = r_last;

    // A handoff always begins with the leading-zero scan
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_state == ST_SKIP) && (r_left == LEFT_W'(NDIG)))
        else $error("number handoff did not start the scan");

    // While busy at least one digit remains to send
    a_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_left != '0))
        else $error("digit count ran out while busy");

    // Only a minus sign or a decimal digit is ever presented
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_char == ASCII_MINUS ||
                      (r_char >= ASCII_ZERO && r_char <= ASCII_ZERO + CHAR_W'(9))))
        else $error("illegal character presented");

    // A minus sign is never the end of a run
    a_sign_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_char == ASCII_MINUS) |-> !r_last)
        else $error("minus sign marked as last");

endmodule

### design/signed_int_to_decimal_ascii.sv
// Top level: signed 32-bit integer to decimal ASCII character stream.
//
// Usage:
//   i_num  : valid/ready channel carrying one signed 32-bit number per transfer.
//   o_char : valid/ready channel carrying one ASCII character per transfer, with
//            last set on the final character of each number.
//   A negative number sends '-' first, then digits most significant first with
//   no leading zeros; zero sends a single '0'. -2147483648 prints in full.
// Operation:
//   The dabble stage forms ten BCD digits one magnitude bit per cycle, then
//   hands them off. The character stage drops leading zeros one per cycle,
//   then sends one character per cycle while the receiver keeps ready high.
//   Dropped zeros and digits always add up to ten. The next number is
//   accepted once the dabble stage has handed the previous one off, so its
//   conversion overlaps the previous character output.
// Reset: synchronous, active low; both stages return to idle, no output valid.
// Stall: a held-off character stays in the output register; the character
//   stage and then the dabble stage wait, and i_num.ready drops.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii import sida_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sida_num_if.snk    i_num,
    sida_char_if.src   o_char
);

    logic  w_conv_valid;
    logic  w_conv_ready;
    t_conv w_conv;

    // Bit-serial binary to BCD
    sida_dabble u_dabble (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_num        (i_num),
        .o_conv_valid (w_conv_valid),
        .i_conv_ready (w_conv_ready),
        .o_conv       (w_conv)
    );

    // Digit-serial character output
    sida_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_conv_valid (w_conv_valid),
        .o_conv_ready (w_conv_ready),
        .i_conv       (w_conv),
        .o_char       (o_char)
    );

endmodule

### test/sida_text_checker.sv
// Checker for the decimal text converter: predicts each number's characters and compares them.
`timescale 1ns / 1ps

module sida_text_checker import sida_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_num_valid,
    input  logic                    i_num_ready,
    input  logic signed [NUM_W-1:0] i_number,
    input  logic                    i_char_valid,
    input  logic                    i_char_ready,
    input  logic [CHAR_W-1:0]       i_character,
    input  logic                    i_last,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_num_count,
    output int                      o_char_count
);

    // One expected character of the output text
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } t_text_char;

    t_text_char text_q[$];
    int         fail_count = 0;
    int         num_count  = 0;
    int         char_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_num_count  = 0;
        o_char_count = 0;
    end

    // Append the decimal text of one number to the expected characters
    function automatic void queue_decimal_text(input logic [NUM_W-1:0] raw);
        logic              negative;
        logic [NUM_W-1:0]  mag;
        logic [CHAR_W-1:0] digits [NDIG];
        int                ndig;
        t_text_char        c;
        negative = raw[NUM_W-1];
        // unsigned magnitude, so the most negative value keeps all its digits
        mag  = negative ? (NUM_W'(0) - raw) : raw;
        ndig = 0;
        // least significant first; zero still gives one digit
        do begin
            digits[ndig] = ASCII_ZERO + CHAR_W'(mag % RADIX);
            mag          = mag / RADIX;
            ndig++;
        end while (mag != 0 && ndig < NDIG);
        if (negative) begin
            c.character = ASCII_MINUS;
            c.last      = 1'b0;
            text_q.push_back(c);
        end
        for (int k = ndig - 1; k >= 0; k--) begin
            c.character = digits[k];
            c.last      = (k == 0);
            text_q.push_back(c);
        end
    endfunction

    // Watch both channels at the rising edge
    always @(posedge i_clk) begin : watch
        t_text_char want;
        if (i_rst_n) begin
            if (i_char_valid && i_char_ready) begin
                char_count++;
                if (text_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: character with nothing pending: expected none, got 8'h%02h last %0b",
                             $time, i_character, i_last);
                end else begin
                    want = text_q.pop_front();
                    if (i_character !== want.character) begin
                        fail_count++;
                        $display("%0t: character mismatch: expected 8'h%02h, got 8'h%02h",
                                 $time, want.character, i_character);
                    end
                    if (i_last !== want.last) begin
                        fail_count++;
                        $display("%0t: last mismatch: expected %0b, got %0b",
                                 $time, want.last, i_last);
                    end
                end
            end
            if (i_num_valid && i_num_ready) begin
                num_count++;
                queue_decimal_text(i_number);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= text_q.size();
        o_num_count  <= num_count;
        o_char_count <= char_count;
    end

endmodule

### test/signed_int_to_decimal_ascii_tb.sv
// Testbench top for the decimal text converter: stimulus, receiver back-pressure and verdict.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb import sida_pkg::*; ();

    localparam int RANDOM_ITEMS   = 250;
    localparam int LONG_HOLD      = 400;   // receiver hold-off, long enough to fill the block
    localparam int HOLD_AFTER     = 30;    // numbers accepted before the long hold-off
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 80;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int   fail_count;
    int   pending;
    int   num_count;
    int   char_count;
    int   burst_left;
    int   idle_cycles = 0;
    bit   draining = 1'b0;
    bit   long_hold_done = 1'b0;

    sida_num_if  num_ch ();
    sida_char_if char_ch ();

    signed_int_to_decimal_ascii u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_num   (num_ch),
        .o_char  (char_ch)
    );

    sida_text_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_num_valid  (num_ch.valid),
        .i_num_ready  (num_ch.ready),
        .i_number     (num_ch.number),
        .i_char_valid (char_ch.valid),
        .i_char_ready (char_ch.ready),
        .i_character  (char_ch.character),
        .i_last       (char_ch.last),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_num_count  (num_count),
        .o_char_count (char_count)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: cycles without a transfer on either channel
    always @(posedge i_clk) begin
        if ((num_ch.valid && num_ch.ready) || (char_ch.valid && char_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic longint unsigned ten_pow(input int k);
        longint unsigned p;
        p = 1;
        for (int i = 0; i < k; i++) p = p * 10;
        return p;
    endfunction

    // Random number: full-range words, chosen digit counts, small values, decade edges
    function automatic logic [NUM_W-1:0] random_number();
        longint unsigned mag;
        longint unsigned lo;
        longint unsigned hi;
        int              k;
        bit              neg;
        neg = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: begin
                k  = $urandom_range(1, 10);
                lo = (k == 1) ? 0 : ten_pow(k - 1);
                hi = ten_pow(k) - 1;
                if (hi > 64'd2147483648) hi = 64'd2147483648;
                mag = lo + (longint'($urandom) % (hi - lo + 1));
            end
            2: mag = 64'($urandom_range(0, 999));
            default: begin
                k = $urandom_range(0, 10);
                if (k == 10) mag = 64'd2147483647 + 64'($urandom_range(0, 1));
                else mag = ten_pow(k) + 64'($urandom_range(0, 2)) - 64'd1;
            end
        endcase
        return NUM_W'(neg ? (64'd0 - mag) : mag);
    endfunction

    // Offer one number and hold it until the transfer, then maybe idle between bursts
    task automatic offer_number(input logic [NUM_W-1:0] value);
        int gap;
        num_ch.valid  <= 1'b1;
        num_ch.number <= value;
        do @(posedge i_clk); while (!num_ch.ready);
        @(negedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            if (gap > 0) begin
                num_ch.valid  <= 1'b0;
                num_ch.number <= $urandom;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
    endtask

    // Receiver: runs of steady, random and mostly stalled ready, plus one long hold-off
    initial begin : receiver
        int mode;
        int run_len;
        char_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!long_hold_done && !draining && num_count >= HOLD_AFTER) begin
                @(negedge i_clk);
                char_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                long_hold_done = 1'b1;
            end else begin
                mode    = $urandom_range(0, 2);
                run_len = $urandom_range(5, 60);
                repeat (run_len) begin
                    @(negedge i_clk);
                    if (draining || mode == 0) char_ch.ready <= 1'b1;
                    else if (mode == 1) char_ch.ready <= 1'($urandom_range(0, 1));
                    else char_ch.ready <= ($urandom_range(0, 3) == 0);
                end
            end
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        logic [NUM_W-1:0] directed [$];
        directed = '{
            32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
            32'd2147483647, 32'h8000_0000, -32'sd2147483647, 32'd1000000000,
            32'd999999999, -32'sd999999999, 32'd1000000009, 32'h5555_5555,
            32'hAAAA_AAAA, 32'd123456789, -32'sd123456789, 32'd7, -32'sd5,
            32'd4294967290
        };
        i_rst_n       = 1'b0;
        num_ch.valid  = 1'b0;
        num_ch.number = '0;
        burst_left    = $urandom_range(1, 8);
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // edge values: zero, single digits, decade edges, both 32-bit extremes
        foreach (directed[i]) offer_number(directed[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++) offer_number(random_number());

        // drain: receiver goes steady, wait for every character, then linger
        num_ch.valid <= 1'b0;
        draining = 1'b1;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Converted %0d numbers (edge values, both extremes, random digit counts)",
                 num_count);
        $display("into %0d checked characters under bursty input, random stalls and one long hold-off",
                 char_count);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
